// File: src/cubehash_byte_engine_core_assert.svh
// Assertion macros shared by the engine RTL.
`ifndef CUBEHASH_BYTE_ENGINE_CORE_ASSERT_SVH
`define CUBEHASH_BYTE_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CBH_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cubehash engine check failed");
`define CBH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cubehash engine check failed");
`else
`define CBH_ASSERT_SAME(name, ante, cons)
`define CBH_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: src/cbh_pkg.sv
// Shared types and constants of the CubeHash byte engine.
package cbh_pkg;

  localparam int unsigned WORD_W           = 32;
  localparam int unsigned NUM_WORDS        = 32;
  localparam int unsigned HALF_WORDS       = NUM_WORDS / 2;
  localparam int unsigned MAX_BLOCK_BYTES  = 128;
  localparam int unsigned MAX_DIGEST_BYTES = 64;

  localparam int unsigned ROT_A    = 7;
  localparam int unsigned ROT_B    = 11;
  localparam int unsigned XSWAP_A  = 8;
  localparam int unsigned HSWAP_A  = 2;
  localparam int unsigned XSWAP_B  = 4;
  localparam int unsigned HSWAP_B  = 1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_ABSORB = 2'd1,
    REQ_FINISH = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    CFG_ROUNDS = 2'd0,
    CFG_BLOCK  = 2'd1,
    CFG_DIGEST = 2'd2
  } cfg_idx_t;

endpackage

// File: src/cbh_if.sv
// Valid/ready channel interfaces for requests and digest bytes.
interface cbh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] msg_byte;

  modport source (output valid, output req_type, output msg_byte, input ready);
  modport sink   (input valid, input req_type, input msg_byte, output ready);
endinterface

interface cbh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic       last_byte;

  modport source (output valid, output digest_byte, output last_byte, input ready);
  modport sink   (input valid, input digest_byte, input last_byte, output ready);
endinterface

// File: src/cbh_half_round.sv
// One CubeHash half round: add, rotate, cross xor and swap over the whole state.
module cbh_half_round (
  input  cbh_pkg::state_t words_i,
  input  logic            sel_i,
  output cbh_pkg::state_t words_o
);
  import cbh_pkg::*;

  word_t sum_w [HALF_WORDS];

  function automatic word_t rotl(word_t v, int unsigned s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  always_comb begin
    for (int i = 0; i < HALF_WORDS; i++) begin
      sum_w[i] = words_i[i + HALF_WORDS] + words_i[i];
    end
    for (int i = 0; i < HALF_WORDS; i++) begin
      if (!sel_i) begin
        words_o[i]              = rotl(words_i[i ^ XSWAP_A], ROT_A) ^ sum_w[i];
        words_o[i + HALF_WORDS] = sum_w[i ^ HSWAP_A];
      end else begin
        words_o[i]              = rotl(words_i[i ^ XSWAP_B], ROT_B) ^ sum_w[i];
        words_o[i + HALF_WORDS] = sum_w[i ^ HSWAP_B];
      end
    end
  end

endmodule

// File: src/cubehash_byte_engine_core.sv
// CubeHash r/b-h byte engine: request channel in, digest bytes out.
//
// in_ch carries one request per item: start, absorb one message byte, or
// finish. in_ch.ready is high only while the engine is idle. out_ch carries
// the digest bytes of a finish, byte zero first, last_byte on the final one.
// cfg_we/cfg_index/cfg_data write r, b and the digest length; the user must
// write them only while idle, as the block itself does not enforce it.
// One half round runs per cycle in a single shared unit. A start loads the
// digest length, b and r into the state and runs the initial rounds; an
// absorb xors the byte into the state and runs the block rounds when the byte
// closes a block; a finish xors in the pad byte, runs the block rounds, flips
// the low bit of the last state word, runs the final rounds, then gives one
// digest byte per cycle that out_ch.ready allows, in_ch.ready returning the
// cycle after the last byte is taken.
// A stalled receiver holds the current digest byte on out_ch; the state does
// not change while it waits.
// Reset (rst_n low at a clock edge) zeroes the state and byte position,
// loads r = 16, b = 32, 64 digest bytes, and leaves the engine idle.
`include "cubehash_byte_engine_core_assert.svh"

module cubehash_byte_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  cbh_in_if.sink      in_ch,
  cbh_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import cbh_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} fsm_t;
  typedef enum logic [1:0] {PH_DONE, PH_FIN1, PH_FIN2} phase_t;

  fsm_t        state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [5:0]  idx_r, idx_nxt;
  state_t      words_r, words_nxt;
  logic [5:0]  rounds_r, rounds_nxt;
  logic [7:0]  block_r, block_nxt;
  logic [6:0]  digest_r, digest_nxt;

  state_t      hr_words;
  logic [7:0]  eff_block;
  logic [6:0]  eff_digest;
  logic [10:0] rounds_x2;
  logic [10:0] rounds_x20;
  logic [4:0]  rd_addr;
  logic [1:0]  rd_lane;
  word_t       rd_word;
  logic [7:0]  rd_byte;
  logic [7:0]  ins_byte;
  word_t       xor_word;
  logic [6:0]  pos_inc;
  logic        in_fire;
  logic        out_fire;
  logic        is_last;

  cbh_half_round u_half_round (
    .words_i (words_r),
    .sel_i   (rem_r[0]),
    .words_o (hr_words)
  );

  assign eff_block  = (block_r == 8'd0) ? 8'd1 :
                      (block_r > 8'(MAX_BLOCK_BYTES)) ? 8'(MAX_BLOCK_BYTES) : block_r;
  assign eff_digest = (digest_r == 7'd0) ? 7'd1 :
                      (digest_r > 7'(MAX_DIGEST_BYTES)) ? 7'(MAX_DIGEST_BYTES) : digest_r;
  assign rounds_x2  = {4'd0, rounds_r, 1'b0};
  assign rounds_x20 = ({5'd0, rounds_r} << 4) + ({5'd0, rounds_r} << 2);

  assign rd_addr  = (state_r == ST_EMIT) ? {1'b0, idx_r[5:2]} : pos_r[6:2];
  assign rd_lane  = (state_r == ST_EMIT) ? idx_r[1:0] : pos_r[1:0];
  assign rd_word  = words_r[rd_addr];
  assign rd_byte  = rd_word[{rd_lane, 3'b000} +: 8];
  assign ins_byte = (in_ch.req_type == REQ_ABSORB) ? in_ch.msg_byte : PAD_BYTE;
  assign xor_word = rd_word ^ (word_t'(ins_byte) << {rd_lane, 3'b000});
  assign pos_inc  = pos_r + 7'd1;
  assign is_last  = ({1'b0, idx_r} + 7'd1) == eff_digest;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_EMIT);
  assign out_ch.digest_byte = rd_byte;
  assign out_ch.last_byte   = is_last;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  always_comb begin
    rounds_nxt = rounds_r;
    block_nxt  = block_r;
    digest_nxt = digest_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROUNDS: rounds_nxt = cfg_data[5:0];
        CFG_BLOCK:  block_nxt  = cfg_data;
        CFG_DIGEST: digest_nxt = cfg_data[6:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    words_nxt = words_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.req_type)
            REQ_START: begin
              words_nxt    = '0;
              words_nxt[0] = word_t'(eff_digest);
              words_nxt[1] = word_t'(eff_block);
              words_nxt[2] = word_t'(rounds_r);
              pos_nxt      = '0;
              rem_nxt      = rounds_x20;
              phase_nxt    = PH_DONE;
              state_nxt    = ST_RUN;
            end
            REQ_ABSORB: begin
              words_nxt[rd_addr] = xor_word;
              if (pos_inc == 7'd0 || {1'b0, pos_inc} >= eff_block) begin
                pos_nxt   = '0;
                rem_nxt   = rounds_x2;
                phase_nxt = PH_DONE;
                state_nxt = ST_RUN;
              end else begin
                pos_nxt = pos_inc;
              end
            end
            REQ_FINISH: begin
              words_nxt[rd_addr] = xor_word;
              rem_nxt            = rounds_x2;
              phase_nxt          = PH_FIN1;
              state_nxt          = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (rem_r != 11'd0) begin
          words_nxt = hr_words;
          rem_nxt   = rem_r - 11'd1;
        end else begin
          unique case (phase_r)
            PH_FIN1: begin
              words_nxt[NUM_WORDS-1][0] = ~words_r[NUM_WORDS-1][0];
              rem_nxt   = rounds_x20;
              phase_nxt = PH_FIN2;
            end
            PH_FIN2: begin
              idx_nxt   = '0;
              state_nxt = ST_EMIT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 6'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_DONE;
      rem_r    <= '0;
      pos_r    <= '0;
      idx_r    <= '0;
      words_r  <= '0;
      rounds_r <= 6'd16;
      block_r  <= 8'd32;
      digest_r <= 7'd64;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
      idx_r    <= idx_nxt;
      words_r  <= words_nxt;
      rounds_r <= rounds_nxt;
      block_r  <= block_nxt;
      digest_r <= digest_nxt;
    end
  end

  `CBH_ASSERT_SAME(a_no_overlap, in_ch.ready, !out_ch.valid)
  `CBH_ASSERT_NEXT(a_last_ends_emit, out_fire && is_last, !out_ch.valid && in_ch.ready)
  `CBH_ASSERT_NEXT(a_rem_counts_down, state_r == ST_RUN && rem_r != 11'd0,
                   rem_r == $past(rem_r) - 11'd1)
  `CBH_ASSERT_NEXT(a_start_runs, in_fire && in_ch.req_type == REQ_START, state_r == ST_RUN)

endmodule
